// ===== rtl/core/gse_pkg.sv =====
// Shared types and constants for the grayscale Sobel edge block.
package gse_pkg;

    localparam int MAX_WIDTH  = 2048;
    localparam int MAX_HEIGHT = 2048;

    localparam int DIM_W  = 12;
    localparam int COL_W  = $clog2(MAX_WIDTH);
    localparam int ROW_W  = $clog2(MAX_HEIGHT);
    localparam int PIX_W  = 8;
    localparam int IDX_W  = 2;

    localparam logic [IDX_W-1:0] REG_FRAME_WIDTH  = 2'd0;
    localparam logic [IDX_W-1:0] REG_FRAME_HEIGHT = 2'd1;

    localparam logic [DIM_W-1:0] RESET_WIDTH  = 12'd640;
    localparam logic [DIM_W-1:0] RESET_HEIGHT = 12'd480;
    localparam logic [DIM_W-1:0] MIN_DIM      = 12'd3;
    localparam logic [DIM_W-1:0] MAX_W_DIM    = DIM_W'(MAX_WIDTH);
    localparam logic [DIM_W-1:0] MAX_H_DIM    = DIM_W'(MAX_HEIGHT);

    // Q16 gray coefficients
    localparam logic [15:0] COEF_R = 16'd13933;
    localparam logic [15:0] COEF_G = 16'd46872;
    localparam logic [15:0] COEF_B = 16'd4732;

    localparam int FIFO_DEPTH = 4;
    localparam int FIFO_AW    = $clog2(FIFO_DEPTH);

    typedef struct packed {
        logic             valid;
        logic             pixel;
        logic             emit;
        logic             border;
        logic             last;
        logic [COL_W-1:0] addr;
        logic [PIX_W-1:0] gray;
    } stage_ctl_t;

    typedef struct packed {
        logic [PIX_W-1:0] edge_res;
        logic             frame_end;
    } result_t;

endpackage

// ===== rtl/core/grayscale_sobel_edge_top.sv =====
// Top level of the streaming grayscale Sobel edge magnitude block.
//
// BGR pixels enter in raster order, one per clock unless pix_stall is high; each
// is reduced to gray, passed through two line stores held in one dual-field
// synchronous RAM, and a 3x3 window feeds an L1 Sobel magnitude that is zero on
// the frame border. A released result passes the s1 and s2 registers into the
// result queue; the sustained rate is one request per cycle when not stalled, set
// by the single read-modify-write of the line-store RAM per pixel (read at entry,
// write back in the next cycle). Results trail the input by one line plus one
// pixel; flush requests at the start of a frame drain the trailing border results.
// A four-entry result queue absorbs output stalls; input stall rises only when
// that queue and the pipeline hold four pending results. Writing either size
// register restarts the stream. The line stores are not cleared after reset;
// their content before it is written only reaches border results.
module grayscale_sobel_edge_top
    import gse_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             cfg_valid,
    output logic             cfg_ready,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [DIM_W-1:0] cfg_data,
    input  logic             pix_valid,
    output logic             pix_stall,
    input  logic [PIX_W-1:0] blue,
    input  logic [PIX_W-1:0] green,
    input  logic [PIX_W-1:0] red,
    input  logic             flush,
    output logic             res_valid,
    input  logic             res_stall,
    output logic [PIX_W-1:0] edge_res,
    output logic             frame_end
);

    logic [DIM_W-1:0] frame_width_reg, frame_height_reg;
    logic [DIM_W-1:0] w_eff, h_eff;

    logic [COL_W-1:0] in_col_reg, in_col_next;
    logic [ROW_W-1:0] in_row_reg, in_row_next;
    logic [COL_W-1:0] out_col_reg, out_col_next;
    logic [ROW_W-1:0] out_row_reg, out_row_next;
    logic [DIM_W-1:0] pend_reg, pend_next;

    stage_ctl_t s1_reg, s1_next;
    stage_ctl_t s2_reg, s2_next;

    logic [2*PIX_W-1:0] mem [MAX_WIDTH];
    logic [2*PIX_W-1:0] rd_data_reg;

    logic [PIX_W-1:0] win_reg [9];
    logic [PIX_W-1:0] win_next [9];

    result_t            fifo_mem [FIFO_DEPTH];
    logic [FIFO_AW-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [FIFO_AW:0]   fifo_cnt_reg;
    logic [FIFO_AW:0]   credit_reg, credit_next;

    logic accept, pop, push, cfg_wr, emit, is_pixel;
    logic [24:0] gray_sum;
    logic [PIX_W-1:0] luma_px;
    logic in_first;
    logic col_wrap, row_wrap, ocol_wrap, orow_wrap;
    logic [PIX_W-1:0] top_px, mid_px;
    logic signed [10:0] gx, gy;
    logic [9:0] gx_abs, gy_abs;
    logic [10:0] mag;
    result_t push_item;

    // Clamp the frame size to its legal range
    always_comb
    begin
        w_eff = frame_width_reg;
        if (frame_width_reg < MIN_DIM)
            w_eff = MIN_DIM;
        else if (frame_width_reg > MAX_W_DIM)
            w_eff = MAX_W_DIM;
        h_eff = frame_height_reg;
        if (frame_height_reg < MIN_DIM)
            h_eff = MIN_DIM;
        else if (frame_height_reg > MAX_H_DIM)
            h_eff = MAX_H_DIM;
    end

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready &&
                       (cfg_index == REG_FRAME_WIDTH || cfg_index == REG_FRAME_HEIGHT);
    assign pix_stall = (credit_reg >= (FIFO_AW+1)'(FIFO_DEPTH));
    assign accept    = pix_valid && !pix_stall;
    assign is_pixel  = !flush;

    assign gray_sum = 25'(COEF_R) * 25'(red) + 25'(COEF_G) * 25'(green) +
                      25'(COEF_B) * 25'(blue);
    assign luma_px  = (gray_sum[24:16] > 9'd255) ? 8'hFF : gray_sum[23:16];

    assign in_first  = (in_col_reg == '0) && (in_row_reg == '0);
    assign col_wrap  = ({1'b0, in_col_reg} + 12'd1) >= w_eff;
    assign row_wrap  = ({1'b0, in_row_reg} + 12'd1) >= h_eff;
    assign ocol_wrap = ({1'b0, out_col_reg} + 12'd1) >= w_eff;
    assign orow_wrap = ({1'b0, out_row_reg} + 12'd1) >= h_eff;

    always_comb
    begin
        if (is_pixel)
            emit = {1'b0, pend_reg} >= ({1'b0, w_eff} + 13'd1);
        else
            emit = in_first && (pend_reg != '0);
    end

    // Position counters and pending count
    always_comb
    begin
        in_col_next  = in_col_reg;
        in_row_next  = in_row_reg;
        out_col_next = out_col_reg;
        out_row_next = out_row_reg;
        pend_next    = pend_reg;
        if (cfg_wr)
        begin
            in_col_next  = '0;
            in_row_next  = '0;
            out_col_next = '0;
            out_row_next = '0;
            pend_next    = '0;
        end
        else if (accept)
        begin
            if (is_pixel)
            begin
                if (col_wrap)
                begin
                    in_col_next = '0;
                    in_row_next = row_wrap ? '0 : in_row_reg + 1'b1;
                end
                else
                begin
                    in_col_next = in_col_reg + 1'b1;
                end
            end
            if (emit)
            begin
                if (ocol_wrap)
                begin
                    out_col_next = '0;
                    out_row_next = orow_wrap ? '0 : out_row_reg + 1'b1;
                end
                else
                begin
                    out_col_next = out_col_reg + 1'b1;
                end
            end
            pend_next = pend_reg + DIM_W'(is_pixel) - DIM_W'(emit);
        end
    end

    always_comb
    begin
        s1_next        = '0;
        s1_next.valid  = accept && (is_pixel || emit);
        s1_next.pixel  = is_pixel;
        s1_next.emit   = emit;
        s1_next.border = (out_col_reg == '0) || ({1'b0, out_col_reg} + 12'd2 > w_eff) ||
                         (out_row_reg == '0) || ({1'b0, out_row_reg} + 12'd2 > h_eff);
        s1_next.last   = ocol_wrap && orow_wrap;
        s1_next.addr   = in_col_reg;
        s1_next.gray   = luma_px;
    end

    // Line stores: upper byte two lines up, lower byte one line up
    always_ff @(posedge clk)
    begin
        if (accept && is_pixel)
            rd_data_reg <= mem[in_col_reg];
        if (s1_reg.valid && s1_reg.pixel)
            mem[s1_reg.addr] <= {mid_px, s1_reg.gray};
    end

    assign top_px = rd_data_reg[2*PIX_W-1:PIX_W];
    assign mid_px = rd_data_reg[PIX_W-1:0];

    // Shift the window one column and load the new column
    always_comb
    begin
        for (int i = 0; i < 9; i++)
            win_next[i] = win_reg[i];
        if (s1_reg.valid && s1_reg.pixel)
        begin
            for (int r = 0; r < 3; r++)
            begin
                win_next[r*3+0] = win_reg[r*3+1];
                win_next[r*3+1] = win_reg[r*3+2];
            end
            win_next[2] = top_px;
            win_next[5] = mid_px;
            win_next[8] = s1_reg.gray;
        end
    end

    assign s2_next = s1_reg;

    always_comb
    begin
        gx = -$signed({3'b0, win_reg[0]}) + $signed({3'b0, win_reg[2]})
             - ($signed({3'b0, win_reg[3]}) <<< 1) + ($signed({3'b0, win_reg[5]}) <<< 1)
             - $signed({3'b0, win_reg[6]}) + $signed({3'b0, win_reg[8]});
        gy = $signed({3'b0, win_reg[0]}) + ($signed({3'b0, win_reg[1]}) <<< 1)
             + $signed({3'b0, win_reg[2]}) - $signed({3'b0, win_reg[6]})
             - ($signed({3'b0, win_reg[7]}) <<< 1) - $signed({3'b0, win_reg[8]});
        gx_abs = gx[10] ? 10'(-gx) : gx[9:0];
        gy_abs = gy[10] ? 10'(-gy) : gy[9:0];
        mag    = {1'b0, gx_abs} + {1'b0, gy_abs};
        push_item.edge_res  = 8'h00;
        if (!s2_reg.border)
            push_item.edge_res = (mag > 11'd255) ? 8'hFF : mag[7:0];
        push_item.frame_end = s2_reg.last;
    end

    assign push      = s2_reg.valid && s2_reg.emit;
    assign res_valid = (fifo_cnt_reg != '0);
    assign pop       = res_valid && !res_stall;
    assign edge_res  = fifo_mem[rd_ptr_reg].edge_res;
    assign frame_end = fifo_mem[rd_ptr_reg].frame_end;

    // Reserve a queue slot for every result in flight
    assign credit_next = credit_reg + (FIFO_AW+1)'(accept && emit) - (FIFO_AW+1)'(pop);

    always_ff @(posedge clk)
    begin
        if (push)
            fifo_mem[wr_ptr_reg] <= push_item;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_width_reg  <= RESET_WIDTH;
            frame_height_reg <= RESET_HEIGHT;
            in_col_reg       <= '0;
            in_row_reg       <= '0;
            out_col_reg      <= '0;
            out_row_reg      <= '0;
            pend_reg         <= '0;
            s1_reg           <= '0;
            s2_reg           <= '0;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= '0;
            wr_ptr_reg       <= '0;
            rd_ptr_reg       <= '0;
            fifo_cnt_reg     <= '0;
            credit_reg       <= '0;
        end
        else
        begin
            if (cfg_valid && cfg_ready && cfg_index == REG_FRAME_WIDTH)
                frame_width_reg <= cfg_data;
            if (cfg_valid && cfg_ready && cfg_index == REG_FRAME_HEIGHT)
                frame_height_reg <= cfg_data;
            in_col_reg    <= in_col_next;
            in_row_reg    <= in_row_next;
            out_col_reg   <= out_col_next;
            out_row_reg   <= out_row_next;
            pend_reg      <= pend_next;
            s1_reg        <= s1_next;
            s2_reg        <= s2_next;
            for (int i = 0; i < 9; i++)
                win_reg[i] <= win_next[i];
            if (push)
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            if (pop)
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            fifo_cnt_reg  <= fifo_cnt_reg + (FIFO_AW+1)'(push) - (FIFO_AW+1)'(pop);
            credit_reg    <= credit_next;
        end
    end

endmodule

// ===== tb/sv/grayscale_sobel_edge_top_tb.sv =====
`timescale 1ns / 100ps
// Self-checking testbench for the grayscale Sobel edge block: random and directed frames.
module grayscale_sobel_edge_top_tb
    import gse_pkg::*;
();

    localparam int CLK_HALF      = 4;
    localparam int SETTLE_CYCLES = 12;
    localparam int LONG_HOLD     = 300;
    localparam int RANDOM_PIXELS = 250;
    localparam int RESET_PIXELS  = 40;
    localparam int CLAMP_PIXELS  = 30;
    localparam int TIMEOUT_NS    = 3_000_000;

    localparam logic [IDX_W-1:0] REG_UNUSED_2 = 2'd2;
    localparam logic [IDX_W-1:0] REG_UNUSED_3 = 2'd3;
    localparam logic [DIM_W-1:0] DIM_OVER     = '1;
    localparam logic [PIX_W-1:0] PIX_MIN      = '0;
    localparam logic [PIX_W-1:0] PIX_MAX      = '1;
    localparam logic [PIX_W-1:0] PIX_HALF     = 8'h80;

    typedef enum {IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH} idle_mode_t;
    typedef enum {TEX_UNIFORM, TEX_EXTREME, TEX_FLAT} texture_t;

    typedef struct {
        logic [PIX_W-1:0] b;
        logic [PIX_W-1:0] g;
        logic [PIX_W-1:0] r;
        logic             fl;
    } pix_req_t;

    logic             clk = 1'b0;
    logic             rst_n = 1'b0;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_index = '0;
    logic [DIM_W-1:0] cfg_data = '0;
    logic             pix_valid = 1'b0;
    logic             pix_stall;
    logic [PIX_W-1:0] blue = '0;
    logic [PIX_W-1:0] green = '0;
    logic [PIX_W-1:0] red = '0;
    logic             flush = 1'b0;
    logic             res_valid;
    logic             res_stall = 1'b0;
    logic [PIX_W-1:0] edge_res;
    logic             frame_end;

    grayscale_sobel_edge_top uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .pix_valid (pix_valid),
        .pix_stall (pix_stall),
        .blue      (blue),
        .green     (green),
        .red       (red),
        .flush     (flush),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .edge_res  (edge_res),
        .frame_end (frame_end)
    );

    // Predictor state: gray line stores, 3x3 window, stream positions, size registers
    bit [PIX_W-1:0]   gray_top [MAX_WIDTH];
    bit [PIX_W-1:0]   gray_mid [MAX_WIDTH];
    bit [PIX_W-1:0]   win [9];
    int unsigned      in_col;
    int unsigned      in_line;
    int unsigned      out_pos;
    logic [DIM_W-1:0] width_reg = RESET_WIDTH;
    logic [DIM_W-1:0] height_reg = RESET_HEIGHT;

    pix_req_t pixel_queue[$];
    result_t  edge_expect[$];

    int send_idle_pct = 0;
    int recv_idle_pct = 0;
    int holds_asked = 0;
    int holds_served = 0;
    int hold_left = 0;

    int mismatches = 0;
    int results_checked = 0;
    int frame_ends = 0;
    int requests_taken = 0;
    int size_writes = 0;

    function automatic bit chance(int pct);
        return $urandom_range(99) < pct;
    endfunction

    function automatic int unsigned clamp_dim(logic [DIM_W-1:0] v, int unsigned hi);
        if (v < MIN_DIM)
            return MIN_DIM;
        if (v > hi)
            return hi;
        return v;
    endfunction

    // Advance the predictor by one request; queue the result it releases, if any
    function automatic void predict_request(logic [PIX_W-1:0] b, logic [PIX_W-1:0] g,
                                            logic [PIX_W-1:0] r, logic fl);
        int unsigned    w;
        int unsigned    h;
        int unsigned    total;
        int unsigned    in_lin;
        int unsigned    pending;
        int unsigned    acc;
        int unsigned    ox;
        int unsigned    oy;
        bit [PIX_W-1:0] gray;
        bit [PIX_W-1:0] top;
        bit [PIX_W-1:0] mid;
        bit             emit;
        int             gx;
        int             gy;
        int             mag;
        result_t        res;

        w = clamp_dim(width_reg, MAX_WIDTH);
        h = clamp_dim(height_reg, MAX_HEIGHT);
        total = w * h;
        in_lin = in_line * w + in_col;
        pending = (in_lin + total - out_pos) % total;
        emit = 1'b0;

        if (fl) begin
            // only a frame start with results still owed drains one
            emit = (in_lin == 0) && (pending > 0);
        end else begin
            acc = (COEF_R * r + COEF_G * g + COEF_B * b) >> 16;
            gray = (acc > 255) ? PIX_MAX : acc[PIX_W-1:0];
            top = gray_top[in_col];
            mid = gray_mid[in_col];
            gray_top[in_col] = mid;
            gray_mid[in_col] = gray;
            for (int k = 0; k < 3; k++) begin
                win[k*3]   = win[k*3+1];
                win[k*3+1] = win[k*3+2];
            end
            win[2] = top;
            win[5] = mid;
            win[8] = gray;
            in_col++;
            if (in_col >= w) begin
                in_col = 0;
                in_line++;
                if (in_line >= h)
                    in_line = 0;
            end
            emit = (pending + 1 >= w + 2);
        end

        if (emit) begin
            res.edge_res = '0;
            oy = out_pos / w;
            ox = out_pos % w;
            if (ox >= 1 && ox + 2 <= w && oy >= 1 && oy + 2 <= h) begin
                gx = -int'(win[0]) + int'(win[2]) - 2 * int'(win[3]) + 2 * int'(win[5])
                     - int'(win[6]) + int'(win[8]);
                gy = int'(win[0]) + 2 * int'(win[1]) + int'(win[2]) - int'(win[6])
                     - 2 * int'(win[7]) - int'(win[8]);
                mag = (gx < 0 ? -gx : gx) + (gy < 0 ? -gy : gy);
                res.edge_res = (mag > 255) ? PIX_MAX : PIX_W'(mag);
            end
            res.frame_end = (out_pos + 1 == total);
            out_pos++;
            if (out_pos >= total)
                out_pos = 0;
            edge_expect.push_back(res);
        end
    endfunction

    initial begin
        forever #CLK_HALF clk = ~clk;
    end

    initial begin
        #(TIMEOUT_NS);
        $display("%0t: timeout, %0d results still owed", $time, edge_expect.size());
        $display("Mismatches found");
        $finish;
    end

    // Pixel driver: hold a request until taken, predict on acceptance
    always @(posedge clk or negedge rst_n) begin : drive_pixels
        pix_req_t req;
        if (!rst_n) begin
            pix_valid <= 1'b0;
        end else begin
            if (pix_valid && !pix_stall) begin
                predict_request(blue, green, red, flush);
                requests_taken++;
            end
            if (!pix_valid || !pix_stall) begin
                if (pixel_queue.size() != 0 && !chance(send_idle_pct)) begin
                    req = pixel_queue.pop_front();
                    blue      <= req.b;
                    green     <= req.g;
                    red       <= req.r;
                    flush     <= req.fl;
                    pix_valid <= 1'b1;
                end else begin
                    pix_valid <= 1'b0;
                end
            end
        end
    end

    // Result stall: random, or a long hold-off on request
    always @(posedge clk or negedge rst_n) begin : drive_stall
        if (!rst_n) begin
            res_stall <= 1'b0;
            hold_left = 0;
        end else if (hold_left != 0) begin
            hold_left--;
            res_stall <= 1'b1;
        end else if (holds_served != holds_asked) begin
            holds_served++;
            hold_left = LONG_HOLD;
            res_stall <= 1'b1;
        end else begin
            res_stall <= chance(recv_idle_pct);
        end
    end

    always @(posedge clk) begin : check_results
        result_t want;
        if (rst_n && res_valid && !res_stall) begin
            if (edge_expect.size() == 0) begin
                $display("%0t: unexpected result, expected none, got edge_res=%0d frame_end=%0d",
                         $time, edge_res, frame_end);
                mismatches++;
            end else begin
                want = edge_expect.pop_front();
                if (edge_res !== want.edge_res) begin
                    $display("%0t: edge_res expected %0d, got %0d",
                             $time, want.edge_res, edge_res);
                    mismatches++;
                end
                if (frame_end !== want.frame_end) begin
                    $display("%0t: frame_end expected %0d, got %0d",
                             $time, want.frame_end, frame_end);
                    mismatches++;
                end
                results_checked++;
                if (frame_end)
                    frame_ends++;
            end
        end
    end

    task automatic set_idling(input idle_mode_t mode);
        case (mode)
            IDLE_NONE: begin send_idle_pct = 0;  recv_idle_pct = 0;  end
            IDLE_SEND: begin send_idle_pct = 53; recv_idle_pct = 0;  end
            IDLE_RECV: begin send_idle_pct = 0;  recv_idle_pct = 53; end
            default:   begin send_idle_pct = 33; recv_idle_pct = 33; end
        endcase
    endtask

    function automatic logic [PIX_W-1:0] rand_chan(input texture_t tex);
        case (tex)
            TEX_EXTREME: return chance(50) ? PIX_MIN : PIX_MAX;
            TEX_FLAT:    return PIX_W'($urandom_range(136, 120));
            default:     return PIX_W'($urandom_range(255));
        endcase
    endfunction

    task automatic push_pixel(input logic [PIX_W-1:0] b, input logic [PIX_W-1:0] g,
                              input logic [PIX_W-1:0] r);
        pixel_queue.push_back('{b, g, r, 1'b0});
    endtask

    task automatic push_flush();
        pixel_queue.push_back('{PIX_W'($urandom), PIX_W'($urandom), PIX_W'($urandom), 1'b1});
    endtask

    task automatic push_pixels(input int count, input texture_t tex);
        for (int i = 0; i < count; i++)
            push_pixel(rand_chan(tex), rand_chan(tex), rand_chan(tex));
    endtask

    // Hold until every request is taken and every result is in, then let the pipe empty
    task automatic wait_idle(input int extra);
        while (pixel_queue.size() != 0 || pix_valid)
            @(negedge clk);
        while (edge_expect.size() != 0)
            @(negedge clk);
        repeat (extra) @(posedge clk);
    endtask

    task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [DIM_W-1:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (idx == REG_FRAME_WIDTH)
            width_reg = val;
        else if (idx == REG_FRAME_HEIGHT)
            height_reg = val;
        if (idx == REG_FRAME_WIDTH || idx == REG_FRAME_HEIGHT) begin
            in_col = 0;
            in_line = 0;
            out_pos = 0;
            size_writes++;
        end
    endtask

    initial begin : stimulus
        int          pixels_random;
        int          w;
        int          h;
        int unsigned eff_w;
        int unsigned eff_h;
        int          frames;
        texture_t    tex;

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // sizes from reset: less than a line, so nothing may come out
        set_idling(IDLE_BOTH);
        push_pixels(RESET_PIXELS, TEX_UNIFORM);
        wait_idle(SETTLE_CYCLES);

        // smallest frame: saturated gradients, flush drains and ignored flushes
        set_idling(IDLE_NONE);
        write_reg(REG_FRAME_WIDTH, MIN_DIM);
        write_reg(REG_FRAME_HEIGHT, MIN_DIM);
        push_flush();
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MAX, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MIN, PIX_MAX, PIX_MIN);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MAX);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        // second frame back to back, with a flush in the middle
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_pixel(PIX_MAX, PIX_MAX, PIX_MAX);
        push_flush();
        push_pixel(PIX_HALF, PIX_HALF, PIX_HALF);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        push_pixel(PIX_MIN, PIX_MIN, PIX_MIN);
        repeat (5) push_flush();
        wait_idle(SETTLE_CYCLES);

        // random sessions of small frames; the first one gets a long output hold
        pixels_random = 0;
        while (pixels_random < RANDOM_PIXELS) begin
            set_idling(idle_mode_t'($urandom_range(3)));
            w = chance(10) ? $urandom_range(2) : $urandom_range(12, 3);
            h = chance(10) ? $urandom_range(2) : $urandom_range(8, 3);
            if (chance(50)) begin
                write_reg(REG_FRAME_WIDTH, DIM_W'(w));
                write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
            end else begin
                write_reg(REG_FRAME_HEIGHT, DIM_W'(h));
                write_reg(REG_FRAME_WIDTH, DIM_W'(w));
            end
            if (chance(20))
                write_reg(chance(50) ? REG_UNUSED_2 : REG_UNUSED_3, DIM_W'($urandom));
            eff_w = clamp_dim(DIM_W'(w), MAX_WIDTH);
            eff_h = clamp_dim(DIM_W'(h), MAX_HEIGHT);
            frames = $urandom_range(3, 1);
            tex = texture_t'($urandom_range(2));
            if (holds_asked == 0)
                holds_asked++;
            for (int f = 0; f < frames; f++) begin
                for (int i = 0; i < eff_w * eff_h; i++) begin
                    if (i > 0 && chance(4))
                        push_flush();
                    push_pixel(rand_chan(tex), rand_chan(tex), rand_chan(tex));
                end
                pixels_random += eff_w * eff_h;
            end
            // a cut-off frame is dropped by the next size write
            if (chance(15))
                push_pixels($urandom_range(eff_w * eff_h - 1, 1), tex);
            else
                repeat (eff_w + 1 + $urandom_range(1)) push_flush();
            wait_idle(SETTLE_CYCLES);
        end

        // height above its range, clamped; the start of the frame is checked
        set_idling(IDLE_RECV);
        write_reg(REG_FRAME_WIDTH, MIN_DIM);
        write_reg(REG_FRAME_HEIGHT, DIM_OVER);
        push_pixels(CLAMP_PIXELS, TEX_UNIFORM);
        wait_idle(SETTLE_CYCLES);

        $display("Covered reset sizes, smallest and random frames, clamped sizes, flush drains,");
        $display("a long output hold with input back-pressure, and restarts by size writes");
        $display("Checked %0d results (%0d frame ends) from %0d requests over %0d size writes",
                 results_checked, frame_ends, requests_taken, size_writes);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

// ===== grayscale_sobel_edge_top.f =====
rtl/core/gse_pkg.sv
rtl/core/grayscale_sobel_edge_top.sv
tb/sv/grayscale_sobel_edge_top_tb.sv
